// ----- design/timecode_frame_converter_assert.svh -----
// Assertion macros for the timecode frame converter.
// Included by the top level; depends on nothing else.
`ifndef TIMECODE_FRAME_CONVERTER_ASSERT_SVH
`define TIMECODE_FRAME_CONVERTER_ASSERT_SVH
`ifndef SYNTHESIS
`define TFC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define TFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define TFC_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define TFC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- design/tfc_pkg.sv -----
// Types and constants for the timecode frame converter.
// Used by timecode_frame_converter; depends on nothing.
`default_nettype none
package tfc_pkg;
   localparam logic [6:0] RESET_RATE = 7'd25;
   localparam int HR_BITS = 20;
   localparam int MN_BITS = 6;
   localparam int SC_BITS = 6;
   localparam int LAST_STAGE = HR_BITS + MN_BITS + SC_BITS;
   localparam logic [18:0] FRAMES_HOUR_MUL = 19'd3600;
   localparam logic [12:0] FRAMES_MIN_MUL = 13'd60;
   localparam logic [9:0] HOURS_LIMIT = 10'd24;
   localparam logic [5:0] SIXTY = 6'd60;
   localparam logic FUNC_TO_TIMECODE = 1'b0;
   localparam logic FUNC_TO_COUNT = 1'b1;

   typedef struct packed {
      logic vld;
      logic func;
      logic rate_ok;
      logic range_ok;
      logic [6:0] rate;
      logic [18:0] per_hour;
      logic [12:0] per_min;
      logic [30:0] count;
      logic [30:0] rem;
      logic [HR_BITS-1:0] q_hr;
      logic [MN_BITS-1:0] q_mn;
      logic [SC_BITS-1:0] q_sc;
      logic [9:0] hr;
      logic [5:0] mn;
      logic [5:0] sc;
      logic [6:0] fr;
      logic [28:0] p_h;
      logic [18:0] p_m;
      logic [12:0] p_s;
      logic [30:0] total;
   } tfc_stage_type;
endpackage
`default_nettype wire

// ----- design/timecode_frame_converter.sv -----
// Top level of the timecode frame converter: pipelined division and multiply-add.
// Depends on tfc_pkg and timecode_frame_converter_assert.svh.
//
// One transfer is taken every cycle and busy never rises. Each result appears on the
// rsp_ ports for one cycle with rsp_valid; the receiver cannot stall. A request passes
// through the input register, the 32 restoring division stages with one quotient bit each
// (20 for hours, 6 for minutes and 6 for seconds) and the output register. The rate is
// sampled when an item is taken.
`default_nettype none
`include "timecode_frame_converter_assert.svh"
module timecode_frame_converter #(
   parameter int MAX_RATE = 120
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [6:0]  csr_wdata,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_func,
   input  wire logic [30:0] req_in_frame_count,
   input  wire logic [9:0]  req_in_hours,
   input  wire logic [5:0]  req_in_minutes,
   input  wire logic [5:0]  req_in_seconds,
   input  wire logic [6:0]  req_in_frames,
   output logic             rsp_valid,
   output logic [30:0]      rsp_out_frame_count,
   output logic [30:0]      rsp_out_hours,
   output logic [5:0]       rsp_out_minutes,
   output logic [5:0]       rsp_out_seconds,
   output logic [6:0]       rsp_out_frames,
   output logic             rsp_ok
);
   import tfc_pkg::*;

   logic [6:0] fps_ff;
   tfc_stage_type pipe_ff [0:LAST_STAGE];
   tfc_stage_type first_in;
   logic rate_ok_in;
   logic rsp_valid_ff;
   logic [30:0] count_ff, hours_ff;
   logic [5:0] minutes_ff, seconds_ff;
   logic [6:0] frames_ff;
   logic ok_ff;
   tfc_stage_type last_s;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         fps_ff <= RESET_RATE;
      end else if (csr_we) begin
         fps_ff <= csr_wdata;
      end
   end

   assign rate_ok_in = (fps_ff != 7'd0) && ({3'b000, fps_ff} <= 10'(MAX_RATE));

   always_comb begin
      first_in = '0;
      first_in.vld = start && !busy;
      first_in.func = req_func;
      first_in.rate_ok = rate_ok_in;
      first_in.range_ok = rate_ok_in && (req_in_hours < HOURS_LIMIT) &&
                          (req_in_minutes < SIXTY) && (req_in_seconds < SIXTY) &&
                          (req_in_frames < fps_ff);
      first_in.rate = fps_ff;
      first_in.per_hour = {12'd0, fps_ff} * FRAMES_HOUR_MUL;
      first_in.per_min = {6'd0, fps_ff} * FRAMES_MIN_MUL;
      first_in.count = req_in_frame_count;
      first_in.rem = req_in_frame_count;
      first_in.hr = req_in_hours;
      first_in.mn = req_in_minutes;
      first_in.sc = req_in_seconds;
      first_in.fr = req_in_frames;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_ff[0].vld <= 1'b0;
      end else begin
         pipe_ff[0] <= first_in;
      end
   end

   for (genvar s = 1; s <= LAST_STAGE; s++) begin : g_stage
      localparam int HB = (s <= HR_BITS) ? (HR_BITS - s) : 0;
      localparam int MB = (s > HR_BITS && s <= HR_BITS + MN_BITS) ?
                          (HR_BITS + MN_BITS - s) : 0;
      localparam int SB = (s > HR_BITS + MN_BITS) ? (LAST_STAGE - s) : 0;
      tfc_stage_type prev;
      tfc_stage_type nx;
      logic [38:0] dh;
      logic [18:0] dm;
      logic [12:0] ds;

      assign prev = pipe_ff[s-1];
      assign dh = {20'd0, prev.per_hour} << HB;
      assign dm = {6'd0, prev.per_min} << MB;
      assign ds = {6'd0, prev.rate} << SB;

      always_comb begin
         nx = prev;
         if (s == 1) begin
            nx.p_h = 29'({19'd0, prev.hr} * {10'd0, prev.per_hour});
            nx.p_m = 19'({13'd0, prev.mn} * {6'd0, prev.per_min});
            nx.p_s = 13'({7'd0, prev.sc} * {6'd0, prev.rate});
         end
         if (s == 2) begin
            nx.total = {2'b00, prev.p_h} + {12'd0, prev.p_m} + {18'd0, prev.p_s} +
                       {24'd0, prev.fr};
         end
         if (s <= HR_BITS) begin
            if ({8'd0, prev.rem} >= dh) begin
               nx.rem = prev.rem - dh[30:0];
               nx.q_hr[HB] = 1'b1;
            end
         end else if (s <= HR_BITS + MN_BITS) begin
            if (prev.rem >= {12'd0, dm}) begin
               nx.rem = prev.rem - {12'd0, dm};
               nx.q_mn[MB] = 1'b1;
            end
         end else begin
            if (prev.rem >= {18'd0, ds}) begin
               nx.rem = prev.rem - {18'd0, ds};
               nx.q_sc[SB] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            pipe_ff[s].vld <= 1'b0;
         end else begin
            pipe_ff[s] <= nx;
         end
      end
   end

   assign last_s = pipe_ff[LAST_STAGE];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= last_s.vld;
      end
      if (last_s.func == FUNC_TO_COUNT) begin
         count_ff <= last_s.total;
         hours_ff <= '0;
         minutes_ff <= '0;
         seconds_ff <= '0;
         frames_ff <= '0;
         ok_ff <= last_s.range_ok;
      end else begin
         count_ff <= last_s.count;
         ok_ff <= last_s.rate_ok;
         if (last_s.rate_ok) begin
            hours_ff <= {11'd0, last_s.q_hr};
            minutes_ff <= last_s.q_mn;
            seconds_ff <= last_s.q_sc;
            frames_ff <= last_s.rem[6:0];
         end else begin
            hours_ff <= '0;
            minutes_ff <= '0;
            seconds_ff <= '0;
            frames_ff <= '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_frame_count = count_ff;
   assign rsp_out_hours = hours_ff;
   assign rsp_out_minutes = minutes_ff;
   assign rsp_out_seconds = seconds_ff;
   assign rsp_out_frames = frames_ff;
   assign rsp_ok = ok_ff;

   `TFC_ASSERT_NEXT(a_enter, clock, reset, start, pipe_ff[0].vld)
   `TFC_ASSERT_NEXT(a_leave, clock, reset, last_s.vld, rsp_valid)
   `TFC_ASSERT_IMPLIES(a_hour_rem, clock, reset,
      pipe_ff[HR_BITS].vld && pipe_ff[HR_BITS].rate_ok &&
      pipe_ff[HR_BITS].func == FUNC_TO_TIMECODE,
      pipe_ff[HR_BITS].rem < {12'd0, pipe_ff[HR_BITS].per_hour})
   `TFC_ASSERT_IMPLIES(a_frame_rem, clock, reset,
      last_s.vld && last_s.rate_ok && last_s.func == FUNC_TO_TIMECODE,
      last_s.rem < {24'd0, last_s.rate})
endmodule
`default_nettype wire
